// ----- design/wtlf_pkg.sv -----
`timescale 1ns / 1ps

package wtlf_pkg;

    localparam int FRAC_BITS = 32;
    localparam int MAX_BINS  = 256;
    localparam int BIN_AW    = $clog2(MAX_BINS);
    localparam int BIN_CW    = $clog2(MAX_BINS + 1);

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    // 1.52 and 0.1 in the fixed-point format, rounded
    localparam logic signed [63:0] K152 = ((64'd152 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic signed [63:0] K01  = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

    localparam logic CFG_SLOPE_MIN    = 1'b0;
    localparam logic CFG_ASSIGNED_ERR = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_IDIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [4:0] {
        W_COMPONENT, W_ACQ_ID, W_CAND_ID, W_START_TIME, W_RUN_MIN, W_RUN_MAX,
        W_LENGTH, W_START_FREQ, W_END_FREQ, W_FREQ_WIDTH, W_SLOPE, W_INTERCEPT,
        W_POWER, W_POINTS, W_SNR_TOTAL, W_SNR_MAX, W_NUP_TOTAL, W_NUP_MAX,
        W_WSNR_TOTAL, W_WNUP_TOTAL, W_CUT, W_SLOPE_SIGMA, W_ICPT_SIGMA,
        W_START_SIGMA, W_END_SIGMA, W_STATUS
    } t_word;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            s = Q_MAX;
        end else if (a[63] && b[63] && !s[63]) begin
            s = Q_MIN;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (!a[63] && b[63] && s[63]) begin
            s = Q_MAX;
        end else if (a[63] && !b[63] && !s[63]) begin
            s = Q_MIN;
        end
        return s;
    endfunction

endpackage

// ----- design/wtlf_alu.sv -----
`timescale 1ns / 1ps

module wtlf_alu import wtlf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_alu_req           i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_SQRT} t_astate;

    t_astate             r_state;
    logic [5:0]          r_cnt;
    logic                r_done;
    logic signed [63:0]  r_res;
    logic                r_neg;
    logic [63:0]         r_ma, r_mb;
    logic [63:0]         r_pp;
    logic [1:0]          r_pp_sh;
    logic [127:0]        r_acc;
    logic [63:0]         r_rem, r_lo, r_d, r_q;
    logic [127:0]        r_rad;
    logic [64:0]         r_srem;
    logic [63:0]         r_root;

    logic [63:0]  a_mag, b_mag;
    logic [63:0]  div_hi, div_lo;
    logic [31:0]  pp_x, pp_y;
    logic [127:0] prod_sh;
    logic [64:0]  div_rr;
    logic         div_ge;
    logic [63:0]  n_rem, n_q;
    logic [66:0]  sq_cand, sq_trial;
    logic         sq_ge;
    logic [64:0]  n_srem;
    logic [63:0]  n_root;

    function automatic logic signed [63:0] sat_from(input logic [63:0] hi,
                                                    input logic [63:0] lo,
                                                    input logic neg);
        logic signed [63:0] v;
        if (hi != 64'd0) begin
            v = neg ? Q_MIN : Q_MAX;
        end else if (neg) begin
            v = lo[63] ? Q_MIN : -signed'(lo);
        end else begin
            v = lo[63] ? Q_MAX : signed'(lo);
        end
        return v;
    endfunction

    always_comb begin
        a_mag   = i_a[63] ? 64'(-i_a) : i_a;
        b_mag   = i_b[63] ? 64'(-i_b) : i_b;
        div_hi  = (i_req.op == ALU_IDIV) ? 64'd0 : (a_mag >> (64 - FRAC_BITS));
        div_lo  = (i_req.op == ALU_IDIV) ? a_mag : (a_mag << FRAC_BITS);
        pp_x    = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        pp_y    = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        prod_sh = r_acc >> FRAC_BITS;
        div_rr  = {r_rem, r_lo[63]};
        div_ge  = div_rr >= {1'b0, r_d};
        n_rem   = div_ge ? 64'(div_rr - {1'b0, r_d}) : div_rr[63:0];
        n_q     = {r_q[62:0], div_ge};
        sq_cand  = {r_srem, r_rad[127:126]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_cand >= sq_trial;
        n_srem   = sq_ge ? 65'(sq_cand - sq_trial) : sq_cand[64:0];
        n_root   = {r_root[62:0], sq_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        r_neg <= i_a[63] ^ i_b[63];
                        unique case (i_req.op)
                            ALU_MUL: begin
                                r_ma    <= a_mag;
                                r_mb    <= b_mag;
                                r_acc   <= '0;
                                r_state <= A_MUL;
                            end
                            ALU_DIV, ALU_IDIV: begin
                                if (i_b == 64'sd0) begin
                                    r_res  <= (i_a == 64'sd0) ? 64'sd0 :
                                              (i_a[63] ? Q_MIN : Q_MAX);
                                    r_done <= 1'b1;
                                end else if (div_hi >= b_mag) begin
                                    r_res  <= (i_a[63] ^ i_b[63]) ? Q_MIN : Q_MAX;
                                    r_done <= 1'b1;
                                end else begin
                                    r_rem   <= div_hi;
                                    r_lo    <= div_lo;
                                    r_d     <= b_mag;
                                    r_q     <= '0;
                                    r_state <= A_DIV;
                                end
                            end
                            ALU_SQRT: begin
                                if (i_a <= 64'sd0) begin
                                    r_res  <= 64'sd0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_rad   <= {64'd0, i_a} << FRAC_BITS;
                                    r_srem  <= '0;
                                    r_root  <= '0;
                                    r_state <= A_SQRT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                A_MUL: begin
                    // one 32x32 partial product per cycle, accumulated from its register in the next cycle
                    if (r_cnt < 6'd4) begin
                        r_pp    <= {32'd0, pp_x} * {32'd0, pp_y};
                        r_pp_sh <= 2'(r_cnt[1] + r_cnt[0]);
                    end
                    if (r_cnt != 6'd0 && r_cnt < 6'd5) begin
                        r_acc <= r_acc + (({64'd0, r_pp}) << {r_pp_sh, 5'd0});
                    end
                    if (r_cnt == 6'd5) begin
                        r_res   <= sat_from(prod_sh[127:64], prod_sh[63:0], r_neg);
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                A_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_lo  <= {r_lo[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_res   <= sat_from(64'd0, n_q, r_neg);
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_SQRT: begin
                    r_srem <= n_srem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[125:0], 2'b00};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_res   <= signed'(n_root);
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- design/weighted_track_line_fit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// point     in         i_in_valid / o_in_stall   i_time_in_acq .. i_last_point
// result    out        o_out_valid / i_out_stall o_quantity_code, _value, o_last_word
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One shared unit does all multiply, divide and square root operations. A point
// goes through it and then a search of the stored bins for its time. The final
// point then adds the passes over the bins and the fit, and 26 output words, one
// per cycle when not stalled. Synchronous active-low reset; bin memory needs no
// clearing. The point side is stalled from acceptance until the point is merged,
// or, for the last point of a track, until the last word of the track is loaded.

module weighted_track_line_fit import wtlf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [63:0] i_time_in_acq,
    input  logic signed [63:0] i_time_in_run,
    input  logic signed [63:0] i_frequency,
    input  logic [62:0]        i_amplitude,
    input  logic [62:0]        i_noise_mean,
    input  logic [62:0]        i_noise_variance,
    input  logic [62:0]        i_wide_amplitude,
    input  logic [15:0]        i_component,
    input  logic [31:0]        i_acquisition_id,
    input  logic [31:0]        i_candidate_id,
    input  logic               i_last_point,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_quantity_code,
    output logic signed [63:0] o_quantity_value,
    output logic               o_last_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    typedef struct packed {
        logic signed [63:0] tm;
        logic signed [63:0] pfs;
        logic signed [63:0] ps;
        logic signed [63:0] snr;
        logic signed [63:0] nup;
        logic signed [63:0] wsnr;
        logic signed [63:0] wnup;
    } t_bin;

    typedef enum logic [5:0] {
        S_IDLE, P_SD, P_PF, P_SNR, P_NUP, P_WSNR, P_WNUP, P_RD, P_CMP,
        F1_RD, F1_ACC, F1_DIV, F1_SQ, F_MX, F_MY, F2_RD, F2_XX, F2_XY,
        F_SLOPE, F_IC, F3_RD, F3_MUL, F3_SQ,
        G_A1, G_A2, G_A3, G_A4, G_A5, G_A6,
        G_B1, G_B2, G_B3, G_B4, G_B5, G_B6, G_B7,
        G_R1, G_R2, G_R3,
        H1, H2, H3, H4, H5, H6, H7,
        K1, K2, S_OUT
    } t_state;

    t_state r_state;
    logic   r_issued;

    logic signed [63:0] r_slope_min;
    logic [62:0]        r_assigned_err;

    logic signed [63:0] r_in_t, r_in_tr, r_in_f;
    logic [62:0]        r_in_amp, r_in_nm, r_in_nv, r_in_wa;
    logic [15:0]        r_comp;
    logic [31:0]        r_acq, r_cand;
    logic               r_last;

    logic signed [63:0] r_sd, r_pf, r_snr, r_nup, r_wsnr, r_wnup;

    logic [BIN_CW-1:0]  r_bins, r_idx;
    logic [31:0]        r_pts;
    logic signed [63:0] r_rmin, r_rmax;
    logic               r_ovf;

    t_bin               r_bin_mem [MAX_BINS];
    logic signed [63:0] r_mean_mem [MAX_BINS];
    t_bin               r_rd;
    logic signed [63:0] r_mean_rd;

    logic signed [63:0] r_sx, r_sy, r_sxx, r_cxx, r_cxy, r_chi2, r_mx, r_my;
    logic signed [63:0] r_power, r_tsnr, r_tnup, r_twsnr, r_twnup, r_msnr, r_mnup;
    logic signed [63:0] r_tmin, r_tmax, r_y, r_slope, r_icpt, r_r, r_p;
    logic signed [63:0] r_ds, r_di, r_rho, r_ss, r_se, r_f0, r_f1;
    logic signed [63:0] r_t, r_u, r_c1;
    logic               r_tsel;

    t_word              r_k;
    logic               r_ovalid;
    logic [4:0]         r_ocode;
    logic signed [63:0] r_oval;
    logic               r_olast;

    t_alu_req           alu_req;
    logic               alu_busy;
    logic signed [63:0] alu_a, alu_b, alu_res;
    logic               alu_done;

    logic signed [63:0] amp64, nm64, nv64, wa64, ae64, n64, nq, tv, len, dx, dy;
    logic signed [63:0] fw, word_val;
    logic               bin_we, mean_we, rd_en, point_done, out_load;
    logic [BIN_AW-1:0]  bin_addr;
    t_bin               bin_base, bin_wdata;

    always_comb begin
        amp64 = signed'({1'b0, r_in_amp});
        nm64  = signed'({1'b0, r_in_nm});
        nv64  = signed'({1'b0, r_in_nv});
        wa64  = signed'({1'b0, r_in_wa});
        ae64  = signed'({1'b0, r_assigned_err});
        n64   = signed'({{(64 - BIN_CW){1'b0}}, r_bins});
        nq    = n64 <<< FRAC_BITS;
        tv    = r_tsel ? r_tmax : r_tmin;
        len   = sat_sub(r_rmax, r_rmin);
        dx    = sat_sub(r_rd.tm, r_mx);
        dy    = sat_sub(r_mean_rd, r_my);
        fw    = sat_sub(r_f1, r_f0);
        if (fw < 64'sd0) begin
            fw = sat_sub(64'sd0, fw);
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_busy = 1'b1;
        alu_req.op = ALU_MUL;
        alu_a = 64'sd0;
        alu_b = 64'sd0;
        unique case (r_state)
            P_SD:    begin alu_req.op = ALU_SQRT; alu_a = nv64; end
            P_PF:    begin alu_a = r_in_f; alu_b = amp64; end
            P_SNR:   begin alu_req.op = ALU_DIV; alu_a = amp64; alu_b = nm64; end
            P_NUP:   begin alu_req.op = ALU_DIV; alu_a = amp64 - nm64; alu_b = r_sd; end
            P_WSNR:  begin alu_req.op = ALU_DIV; alu_a = wa64; alu_b = nm64; end
            P_WNUP:  begin alu_req.op = ALU_DIV; alu_a = wa64 - nm64; alu_b = r_sd; end
            F1_DIV:  begin alu_req.op = ALU_DIV; alu_a = r_rd.pfs; alu_b = r_rd.ps; end
            F1_SQ:   begin alu_a = r_rd.tm; alu_b = r_rd.tm; end
            F_MX:    begin alu_req.op = ALU_IDIV; alu_a = r_sx; alu_b = n64; end
            F_MY:    begin alu_req.op = ALU_IDIV; alu_a = r_sy; alu_b = n64; end
            F2_XX:   begin alu_a = dx; alu_b = dx; end
            F2_XY:   begin alu_a = dx; alu_b = dy; end
            F_SLOPE: begin alu_req.op = ALU_DIV; alu_a = r_cxy; alu_b = r_cxx; end
            F_IC:    begin alu_a = r_slope; alu_b = r_mx; end
            F3_MUL:  begin alu_a = r_slope; alu_b = r_rd.tm; end
            F3_SQ:   begin alu_a = r_r; alu_b = r_r; end
            G_A1:    begin alu_req.op = ALU_SQRT; alu_a = r_sxx; end
            G_A2:    begin alu_req.op = ALU_DIV; alu_a = ae64; alu_b = r_t; end
            G_A3:    begin alu_a = K152; alu_b = r_t; end
            G_A4:    begin alu_req.op = ALU_SQRT; alu_a = nq; end
            G_A5:    begin alu_req.op = ALU_DIV; alu_a = ae64; alu_b = r_t; end
            G_A6:    begin alu_a = K152; alu_b = r_t; end
            G_B1:    begin alu_req.op = ALU_IDIV; alu_a = r_chi2; alu_b = n64 - 64'sd2; end
            G_B2:    begin alu_req.op = ALU_DIV; alu_a = r_p; alu_b = r_sxx; end
            G_B3:    begin alu_req.op = ALU_SQRT; alu_a = r_t; end
            G_B4:    begin alu_a = K152; alu_b = r_t; end
            G_B5:    begin alu_req.op = ALU_IDIV; alu_a = r_p; alu_b = n64; end
            G_B6:    begin alu_req.op = ALU_SQRT; alu_a = r_t; end
            G_B7:    begin alu_a = K152; alu_b = r_t; end
            G_R1:    begin alu_a = r_sxx; alu_b = nq; end
            G_R2:    begin alu_req.op = ALU_SQRT; alu_a = r_t; end
            G_R3:    begin alu_req.op = ALU_DIV; alu_a = r_sx; alu_b = r_t; end
            H1:      begin alu_a = tv; alu_b = r_ds; end
            H2:      begin alu_a = r_t; alu_b = r_t; end
            H3:      begin alu_a = r_di; alu_b = r_di; end
            H4:      begin alu_a = tv; alu_b = r_rho; end
            H5:      begin alu_a = r_ds; alu_b = r_di; end
            H6:      begin alu_a = r_c1; alu_b = r_t; end
            H7:      begin alu_req.op = ALU_SQRT; alu_a = r_t; end
            K1:      begin alu_a = r_tmin; alu_b = r_slope; end
            K2:      begin alu_a = sat_add(r_tmin, len); alu_b = r_slope; end
            default: alu_busy = 1'b0;
        endcase
        alu_req.start = alu_busy && !r_issued;
    end

    wtlf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // bin memory access
    always_comb begin
        rd_en    = 1'b0;
        bin_we   = 1'b0;
        bin_addr = r_idx[BIN_AW-1:0];
        bin_base = r_rd;
        point_done = 1'b0;
        if (r_state == P_RD) begin
            if (r_idx == r_bins) begin
                bin_base   = '0;
                point_done = 1'b1;
                bin_we     = (r_bins < BIN_CW'(MAX_BINS));
            end else begin
                rd_en = 1'b1;
            end
        end else if (r_state == P_CMP) begin
            if (r_rd.tm == r_in_t) begin
                bin_we     = 1'b1;
                point_done = 1'b1;
            end
        end else if (r_state == F1_RD || r_state == F2_RD || r_state == F3_RD) begin
            rd_en = (r_idx != r_bins);
        end
        bin_wdata.tm   = r_in_t;
        bin_wdata.pfs  = sat_add(bin_base.pfs, r_pf);
        bin_wdata.ps   = sat_add(bin_base.ps, amp64);
        bin_wdata.snr  = sat_add(bin_base.snr, r_snr);
        bin_wdata.nup  = sat_add(bin_base.nup, r_nup);
        bin_wdata.wsnr = sat_add(bin_base.wsnr, r_wsnr);
        bin_wdata.wnup = sat_add(bin_base.wnup, r_wnup);
        mean_we = (r_state == F1_SQ) && alu_done;
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bin_mem[bin_addr] <= bin_wdata;
        end
        if (mean_we) begin
            r_mean_mem[bin_addr] <= r_y;
        end
        if (rd_en) begin
            r_rd      <= r_bin_mem[bin_addr];
            r_mean_rd <= r_mean_mem[bin_addr];
        end
    end

    always_comb begin
        unique case (r_k)
            W_COMPONENT:   word_val = signed'({48'd0, r_comp});
            W_ACQ_ID:      word_val = signed'({32'd0, r_acq});
            W_CAND_ID:     word_val = signed'({32'd0, r_cand});
            W_START_TIME:  word_val = r_tmin;
            W_RUN_MIN:     word_val = r_rmin;
            W_RUN_MAX:     word_val = r_rmax;
            W_LENGTH:      word_val = len;
            W_START_FREQ:  word_val = r_f0;
            W_END_FREQ:    word_val = r_f1;
            W_FREQ_WIDTH:  word_val = fw;
            W_SLOPE:       word_val = r_slope;
            W_INTERCEPT:   word_val = r_icpt;
            W_POWER:       word_val = r_power;
            W_POINTS:      word_val = signed'({32'd0, r_pts});
            W_SNR_TOTAL:   word_val = r_tsnr;
            W_SNR_MAX:     word_val = r_msnr;
            W_NUP_TOTAL:   word_val = r_tnup;
            W_NUP_MAX:     word_val = r_mnup;
            W_WSNR_TOTAL:  word_val = r_twsnr;
            W_WNUP_TOTAL:  word_val = r_twnup;
            W_CUT:         word_val = (r_slope > r_slope_min) ? 64'sd0 : 64'sd1;
            W_SLOPE_SIGMA: word_val = r_ds;
            W_ICPT_SIGMA:  word_val = r_di;
            W_START_SIGMA: word_val = r_ss;
            W_END_SIGMA:   word_val = r_se;
            W_STATUS:      word_val = signed'({62'd0, r_bins < BIN_CW'(2), r_ovf});
            default:       word_val = 64'sd0;
        endcase
        out_load = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_issued       <= 1'b0;
            r_ovalid       <= 1'b0;
            r_bins         <= '0;
            r_pts          <= '0;
            r_rmin         <= Q_MAX;
            r_rmax         <= Q_MIN;
            r_ovf          <= 1'b0;
            r_slope_min    <= Q_MIN;
            r_assigned_err <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLOPE_MIN:    r_slope_min    <= signed'(i_cfg_data);
                    CFG_ASSIGNED_ERR: r_assigned_err <= i_cfg_data[62:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (alu_req.start) begin
                r_issued <= 1'b1;
            end
            if (alu_done) begin
                r_issued <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_t   <= i_time_in_acq;
                        r_in_tr  <= i_time_in_run;
                        r_in_f   <= i_frequency;
                        r_in_amp <= i_amplitude;
                        r_in_nm  <= i_noise_mean;
                        r_in_nv  <= i_noise_variance;
                        r_in_wa  <= i_wide_amplitude;
                        r_comp   <= i_component;
                        r_acq    <= i_acquisition_id;
                        r_cand   <= i_candidate_id;
                        r_last   <= i_last_point;
                        r_state  <= P_SD;
                    end
                end
                P_SD:   if (alu_done) begin r_sd   <= alu_res; r_state <= P_PF;   end
                P_PF:   if (alu_done) begin r_pf   <= alu_res; r_state <= P_SNR;  end
                P_SNR:  if (alu_done) begin r_snr  <= alu_res; r_state <= P_NUP;  end
                P_NUP:  if (alu_done) begin r_nup  <= alu_res; r_state <= P_WSNR; end
                P_WSNR: if (alu_done) begin r_wsnr <= alu_res; r_state <= P_WNUP; end
                P_WNUP: begin
                    if (alu_done) begin
                        r_wnup  <= alu_res;
                        r_idx   <= '0;
                        r_state <= P_RD;
                    end
                end
                P_RD: begin
                    if (r_idx == r_bins) begin
                        if (bin_we) begin
                            r_bins <= r_bins + BIN_CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else begin
                        r_state <= P_CMP;
                    end
                end
                P_CMP: begin
                    if (!point_done) begin
                        r_idx   <= r_idx + BIN_CW'(1);
                        r_state <= P_RD;
                    end
                end
                F1_RD: begin
                    if (r_idx == r_bins) begin
                        r_idx   <= '0;
                        r_state <= (r_bins == '0) ? F2_RD : F_MX;
                    end else begin
                        r_state <= F1_ACC;
                    end
                end
                F1_ACC: begin
                    r_sx    <= sat_add(r_sx, r_rd.tm);
                    r_power <= sat_add(r_power, r_rd.ps);
                    r_tsnr  <= sat_add(r_tsnr, r_rd.snr);
                    r_tnup  <= sat_add(r_tnup, r_rd.nup);
                    r_twsnr <= sat_add(r_twsnr, r_rd.wsnr);
                    r_twnup <= sat_add(r_twnup, r_rd.wnup);
                    if (r_idx == '0 || r_rd.snr > r_msnr) r_msnr <= r_rd.snr;
                    if (r_idx == '0 || r_rd.nup > r_mnup) r_mnup <= r_rd.nup;
                    if (r_idx == '0 || r_rd.tm < r_tmin)  r_tmin <= r_rd.tm;
                    if (r_idx == '0 || r_rd.tm > r_tmax)  r_tmax <= r_rd.tm;
                    if (r_rd.ps == 64'sd0) begin
                        r_y     <= 64'sd0;
                        r_state <= F1_SQ;
                    end else begin
                        r_state <= F1_DIV;
                    end
                end
                F1_DIV: if (alu_done) begin r_y <= alu_res; r_state <= F1_SQ; end
                F1_SQ: begin
                    if (alu_done) begin
                        r_sxx   <= sat_add(r_sxx, alu_res);
                        r_sy    <= sat_add(r_sy, r_y);
                        r_idx   <= r_idx + BIN_CW'(1);
                        r_state <= F1_RD;
                    end
                end
                F_MX: if (alu_done) begin r_mx <= alu_res; r_state <= F_MY; end
                F_MY: if (alu_done) begin r_my <= alu_res; r_state <= F2_RD; end
                F2_RD: begin
                    if (r_idx == r_bins) begin
                        if (r_cxx == 64'sd0) begin
                            r_slope <= 64'sd0;
                            r_state <= F_IC;
                        end else begin
                            r_state <= F_SLOPE;
                        end
                    end else begin
                        r_state <= F2_XX;
                    end
                end
                F2_XX: begin
                    if (alu_done) begin
                        r_cxx   <= sat_add(r_cxx, alu_res);
                        r_state <= F2_XY;
                    end
                end
                F2_XY: begin
                    if (alu_done) begin
                        r_cxy   <= sat_add(r_cxy, alu_res);
                        r_idx   <= r_idx + BIN_CW'(1);
                        r_state <= F2_RD;
                    end
                end
                F_SLOPE: if (alu_done) begin r_slope <= alu_res; r_state <= F_IC; end
                F_IC: begin
                    if (alu_done) begin
                        r_icpt  <= sat_sub(r_my, alu_res);
                        r_idx   <= '0;
                        r_state <= F3_RD;
                    end
                end
                F3_RD: begin
                    if (r_idx == r_bins) begin
                        if (r_bins > BIN_CW'(2)) begin
                            r_state <= (r_chi2 < K01) ? G_A1 : G_B1;
                        end else begin
                            r_state <= K1;
                        end
                    end else begin
                        r_state <= F3_MUL;
                    end
                end
                F3_MUL: begin
                    if (alu_done) begin
                        r_r     <= sat_sub(sat_sub(r_mean_rd, alu_res), r_icpt);
                        r_state <= F3_SQ;
                    end
                end
                F3_SQ: begin
                    if (alu_done) begin
                        r_chi2  <= sat_add(r_chi2, alu_res);
                        r_idx   <= r_idx + BIN_CW'(1);
                        r_state <= F3_RD;
                    end
                end
                // small chi-square: assumed frequency error
                G_A1: if (alu_done) begin r_t  <= alu_res; r_state <= G_A2; end
                G_A2: if (alu_done) begin r_t  <= alu_res; r_state <= G_A3; end
                G_A3: if (alu_done) begin r_ds <= alu_res; r_state <= G_A4; end
                G_A4: if (alu_done) begin r_t  <= alu_res; r_state <= G_A5; end
                G_A5: if (alu_done) begin r_t  <= alu_res; r_state <= G_A6; end
                G_A6: if (alu_done) begin r_di <= alu_res; r_state <= G_R1; end
                // otherwise scale by reduced chi-square
                G_B1: if (alu_done) begin r_p  <= alu_res; r_state <= G_B2; end
                G_B2: if (alu_done) begin r_t  <= alu_res; r_state <= G_B3; end
                G_B3: if (alu_done) begin r_t  <= alu_res; r_state <= G_B4; end
                G_B4: if (alu_done) begin r_ds <= alu_res; r_state <= G_B5; end
                G_B5: if (alu_done) begin r_t  <= alu_res; r_state <= G_B6; end
                G_B6: if (alu_done) begin r_t  <= alu_res; r_state <= G_B7; end
                G_B7: if (alu_done) begin r_di <= alu_res; r_state <= G_R1; end
                G_R1: if (alu_done) begin r_t  <= alu_res; r_state <= G_R2; end
                G_R2: if (alu_done) begin r_t  <= alu_res; r_state <= G_R3; end
                G_R3: begin
                    if (alu_done) begin
                        r_rho   <= sat_sub(64'sd0, alu_res);
                        r_tsel  <= 1'b0;
                        r_state <= H1;
                    end
                end
                H1: if (alu_done) begin r_t  <= alu_res; r_state <= H2; end
                H2: if (alu_done) begin r_u  <= alu_res; r_state <= H3; end
                H3: begin
                    if (alu_done) begin
                        r_u     <= sat_add(r_u, alu_res);
                        r_state <= H4;
                    end
                end
                H4: if (alu_done) begin r_c1 <= alu_res; r_state <= H5; end
                H5: if (alu_done) begin r_t  <= alu_res; r_state <= H6; end
                H6: begin
                    if (alu_done) begin
                        r_t     <= sat_add(r_u, sat_add(alu_res, alu_res));
                        r_state <= H7;
                    end
                end
                H7: begin
                    if (alu_done) begin
                        if (r_tsel) begin
                            r_se    <= alu_res;
                            r_state <= K1;
                        end else begin
                            r_ss    <= alu_res;
                            r_tsel  <= 1'b1;
                            r_state <= H1;
                        end
                    end
                end
                K1: if (alu_done) begin r_f0 <= sat_add(alu_res, r_icpt); r_state <= K2; end
                K2: begin
                    if (alu_done) begin
                        r_f1    <= sat_add(alu_res, r_icpt);
                        r_k     <= W_COMPONENT;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_ovalid <= 1'b1;
                        r_ocode  <= r_k;
                        r_oval   <= word_val;
                        r_olast  <= (r_k == W_STATUS);
                        if (r_k == W_STATUS) begin
                            r_bins  <= '0;
                            r_pts   <= '0;
                            r_rmin  <= Q_MAX;
                            r_rmax  <= Q_MIN;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= t_word'(r_k + 5'd1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (point_done) begin
                if (bin_we) begin
                    if (r_pts != 32'hFFFF_FFFF) r_pts <= r_pts + 32'd1;
                    if (r_in_tr < r_rmin) r_rmin <= r_in_tr;
                    if (r_in_tr > r_rmax) r_rmax <= r_in_tr;
                end
                if (r_last) begin
                    r_sx    <= '0;  r_sy    <= '0;  r_sxx   <= '0;
                    r_cxx   <= '0;  r_cxy   <= '0;  r_chi2  <= '0;
                    r_mx    <= '0;  r_my    <= '0;  r_power <= '0;
                    r_tsnr  <= '0;  r_tnup  <= '0;  r_twsnr <= '0;
                    r_twnup <= '0;  r_msnr  <= '0;  r_mnup  <= '0;
                    r_tmin  <= '0;  r_tmax  <= '0;  r_ds    <= '0;
                    r_di    <= '0;  r_ss    <= '0;  r_se    <= '0;
                    r_idx   <= '0;
                    r_state <= F1_RD;
                end else begin
                    r_state <= S_IDLE;
                end
            end
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_quantity_code  = r_ocode;
    assign o_quantity_value = r_oval;
    assign o_last_word      = r_olast;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wtlf_pkg::*;

    localparam longint QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint QMIN = 64'sh8000_0000_0000_0000;
    localparam int     WATCHDOG_LIMIT = 300000;
    localparam int     IDLE_PCT = 34;

    typedef struct {
        longint      tacq;
        longint      trun;
        longint      freq;
        logic [62:0] amp;
        logic [62:0] nmean;
        logic [62:0] nvar;
        logic [62:0] wamp;
        logic [15:0] comp;
        logic [31:0] acq;
        logic [31:0] cand;
        bit          last;
    } t_point;

    typedef struct {
        t_word  code;
        longint value;
        bit     last;
    } t_exp_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [63:0] i_time_in_acq;
    logic signed [63:0] i_time_in_run;
    logic signed [63:0] i_frequency;
    logic [62:0]        i_amplitude;
    logic [62:0]        i_noise_mean;
    logic [62:0]        i_noise_variance;
    logic [62:0]        i_wide_amplitude;
    logic [15:0]        i_component;
    logic [31:0]        i_acquisition_id;
    logic [31:0]        i_candidate_id;
    logic               i_last_point;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [4:0]         o_quantity_code;
    logic signed [63:0] o_quantity_value;
    logic               o_last_word;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [63:0]        i_cfg_data;

    weighted_track_line_fit DUT (.*);

    t_point    pending_points[$];
    t_exp_word expected_words[$];
    int        errs = 0;
    int        quiet_cycles = 0;
    bit        calm = 0;
    bit        point_taken = 0;

    // track state of the predictor
    longint      trk_time[MAX_BINS];
    longint      trk_pf[MAX_BINS];
    longint      trk_pw[MAX_BINS];
    longint      trk_snr[MAX_BINS];
    longint      trk_nup[MAX_BINS];
    longint      trk_wsnr[MAX_BINS];
    longint      trk_wnup[MAX_BINS];
    longint      trk_mean[MAX_BINS];
    int          trk_bins = 0;
    int unsigned trk_points = 0;
    longint      trk_rmin = QMAX;
    longint      trk_rmax = QMIN;
    bit          trk_ovf = 0;
    longint      cut_slope = QMIN;
    longint      fixed_err = 0;

    function automatic void queue_point(t_point p);
        pending_points.insert(pending_points.size(), p);
    endfunction

    function automatic void queue_word(t_exp_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // ---------------- fixed-point arithmetic ----------------
    function automatic logic [63:0] absval(longint a);
        logic [63:0] u;
        u = a;
        return a < 0 ? -u : u;
    endfunction

    function automatic longint clamp(logic [127:0] m, bit neg);
        if (neg) return (m >= 128'h8000_0000_0000_0000) ? QMIN : -longint'(m[63:0]);
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? QMAX : longint'(m[63:0]);
    endfunction

    function automatic longint sadd(longint a, longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint ssub(longint a, longint b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint fmul(longint a, longint b);
        logic [127:0] p;
        p = {64'b0, absval(a)} * {64'b0, absval(b)};
        return clamp(p >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    function automatic longint fdiv(longint a, longint b);
        logic [127:0] m;
        logic [127:0] d;
        bit           neg;
        neg = (a < 0) != (b < 0);
        if (b == 0) return a > 0 ? QMAX : (a < 0 ? QMIN : 0);
        m = {64'b0, absval(a)} << FRAC_BITS;
        d = {64'b0, absval(b)};
        if ((m >> 64) >= d) return neg ? QMIN : QMAX;
        return clamp(m / d, neg);
    endfunction

    function automatic longint fsqrt(longint a);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] t;
        if (a <= 0) return 0;
        n = {64'b0, a} << FRAC_BITS;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= n) r = t;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic longint edge_sigma(longint t, longint ds, longint di, longint rho);
        longint a;
        longint s;
        longint c;
        a = fmul(t, ds);
        s = sadd(fmul(a, a), fmul(di, di));
        c = fmul(fmul(t, rho), fmul(ds, di));
        return fsqrt(sadd(s, sadd(c, c)));
    endfunction

    // ---------------- predictor ----------------
    function automatic void fit_track(t_point p);
        longint v[26];
        int     n;
        longint nq, sx, sy, sxx, cxx, cxy, chi2, mx, my;
        longint pw, tsnr, tnup, twsnr, twnup, msnr, mnup, tmin, tmax;
        longint slope, icpt, ds, di, ss, se, len, f0, f1, w, x, y, dx, dy, r, pv, rho;
        n = trk_bins;
        nq = longint'(n) <<< FRAC_BITS;
        {sx, sy, sxx, cxx, cxy, chi2, mx, my} = '0;
        {pw, tsnr, tnup, twsnr, twnup, msnr, mnup, tmin, tmax} = '0;
        {ds, di, ss, se} = '0;
        for (int i = 0; i < n; i++) begin
            x = trk_time[i];
            y = trk_pw[i] == 0 ? 0 : fdiv(trk_pf[i], trk_pw[i]);
            trk_mean[i] = y;
            sx = sadd(sx, x);
            sy = sadd(sy, y);
            sxx = sadd(sxx, fmul(x, x));
            pw = sadd(pw, trk_pw[i]);
            tsnr = sadd(tsnr, trk_snr[i]);
            tnup = sadd(tnup, trk_nup[i]);
            twsnr = sadd(twsnr, trk_wsnr[i]);
            twnup = sadd(twnup, trk_wnup[i]);
            if (i == 0 || trk_snr[i] > msnr) msnr = trk_snr[i];
            if (i == 0 || trk_nup[i] > mnup) mnup = trk_nup[i];
            if (i == 0 || x < tmin) tmin = x;
            if (i == 0 || x > tmax) tmax = x;
        end
        if (n > 0) begin
            mx = sx / longint'(n);
            my = sy / longint'(n);
        end
        for (int i = 0; i < n; i++) begin
            dx = ssub(trk_time[i], mx);
            dy = ssub(trk_mean[i], my);
            cxx = sadd(cxx, fmul(dx, dx));
            cxy = sadd(cxy, fmul(dx, dy));
        end
        slope = cxx == 0 ? 0 : fdiv(cxy, cxx);
        icpt = ssub(my, fmul(slope, mx));
        for (int i = 0; i < n; i++) begin
            r = ssub(ssub(trk_mean[i], fmul(slope, trk_time[i])), icpt);
            chi2 = sadd(chi2, fmul(r, r));
        end
        if (n > 2) begin
            if (chi2 < K01) begin
                ds = fmul(K152, fdiv(fixed_err, fsqrt(sxx)));
                di = fmul(K152, fdiv(fixed_err, fsqrt(nq)));
            end else begin
                pv = chi2 / longint'(n - 2);
                ds = fmul(K152, fsqrt(fdiv(pv, sxx)));
                di = fmul(K152, fsqrt(pv / longint'(n)));
            end
            rho = ssub(0, fdiv(sx, fsqrt(fmul(sxx, nq))));
            ss = edge_sigma(tmin, ds, di, rho);
            se = edge_sigma(tmax, ds, di, rho);
        end
        len = ssub(trk_rmax, trk_rmin);
        f0 = sadd(fmul(tmin, slope), icpt);
        f1 = sadd(fmul(sadd(tmin, len), slope), icpt);
        w = ssub(f1, f0);
        if (w < 0) w = ssub(0, w);

        v = '{longint'(p.comp), longint'(p.acq), longint'(p.cand), tmin, trk_rmin,
              trk_rmax, len, f0, f1, w, slope, icpt, pw, longint'(trk_points), tsnr,
              msnr, tnup, mnup, twsnr, twnup, (slope > cut_slope) ? 0 : 1, ds, di,
              ss, se, (trk_ovf ? 1 : 0) | (n < 2 ? 2 : 0)};
        for (int k = 0; k < 26; k++) begin
            queue_word('{t_word'(k), v[k], k == 25});
        end
        trk_bins = 0;
        trk_points = 0;
        trk_rmin = QMAX;
        trk_rmax = QMIN;
        trk_ovf = 0;
    endfunction

    function automatic void merge_point(t_point p);
        longint sd, amp, nm, wa;
        int     b;
        amp = longint'({1'b0, p.amp});
        nm = longint'({1'b0, p.nmean});
        wa = longint'({1'b0, p.wamp});
        sd = fsqrt(longint'({1'b0, p.nvar}));
        b = 0;
        while (b < trk_bins && trk_time[b] != p.tacq) b++;
        if (b == trk_bins && trk_bins == MAX_BINS) begin
            trk_ovf = 1;     // table full: point dropped
        end else begin
            if (b == trk_bins) begin
                trk_time[b] = p.tacq;
                {trk_pf[b], trk_pw[b], trk_snr[b], trk_nup[b]} = '0;
                {trk_wsnr[b], trk_wnup[b]} = '0;
                trk_bins++;
            end
            trk_pf[b] = sadd(trk_pf[b], fmul(p.freq, amp));
            trk_pw[b] = sadd(trk_pw[b], amp);
            trk_snr[b] = sadd(trk_snr[b], fdiv(amp, nm));
            trk_nup[b] = sadd(trk_nup[b], fdiv(amp - nm, sd));
            trk_wsnr[b] = sadd(trk_wsnr[b], fdiv(wa, nm));
            trk_wnup[b] = sadd(trk_wnup[b], fdiv(wa - nm, sd));
            if (trk_points != 32'hFFFF_FFFF) trk_points++;
            if (p.trun < trk_rmin) trk_rmin = p.trun;
            if (p.trun > trk_rmax) trk_rmax = p.trun;
        end
        if (p.last) fit_track(p);
    endfunction

    // ---------------- clock, reset ----------------
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- point driver ----------------
    always @(negedge i_clk) begin
        t_point p;
        if (i_rst_n) begin
            if (!i_in_valid || point_taken) begin
                if (pending_points.size() > 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    p = pending_points.pop_front();
                    i_in_valid       <= 1'b1;
                    i_time_in_acq    <= p.tacq;
                    i_time_in_run    <= p.trun;
                    i_frequency      <= p.freq;
                    i_amplitude      <= p.amp;
                    i_noise_mean     <= p.nmean;
                    i_noise_variance <= p.nvar;
                    i_wide_amplitude <= p.wamp;
                    i_component      <= p.comp;
                    i_acquisition_id <= p.acq;
                    i_candidate_id   <= p.cand;
                    i_last_point     <= p.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_point    p;
        t_exp_word e;
        bit        busy;
        busy = 0;
        point_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SLOPE_MIN) cut_slope = i_cfg_data;
                else fixed_err = longint'({1'b0, i_cfg_data[62:0]});
            end
            if (i_in_valid && !o_in_stall) begin
                p = '{i_time_in_acq, i_time_in_run, i_frequency, i_amplitude,
                      i_noise_mean, i_noise_variance, i_wide_amplitude, i_component,
                      i_acquisition_id, i_candidate_id, i_last_point};
                merge_point(p);
                busy = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                busy = 1;
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: code %0d value %h",
                           o_quantity_code, o_quantity_value);
                    errs++;
                end else begin
                    e = expected_words.pop_front();
                    if (o_quantity_code !== e.code) begin
                        $error("quantity_code: expected %0d, got %0d", e.code,
                               o_quantity_code);
                        errs++;
                    end
                    if (o_quantity_value !== e.value) begin
                        $error("quantity_value (code %0d): expected %h, got %h",
                               e.code, e.value, o_quantity_value);
                        errs++;
                    end
                    if (o_last_word !== e.last) begin
                        $error("last_word (code %0d): expected %0d, got %0d",
                               e.code, e.last, o_last_word);
                        errs++;
                    end
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic longint qv(int v);
        return longint'(v) <<< FRAC_BITS;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_point mkpt(longint ta, longint tr, longint f, longint a,
                                    longint nm, longint nv, longint wa, bit last);
        t_point p;
        p = '{ta, tr, f, a[62:0], nm[62:0], nv[62:0], wa[62:0], 16'($urandom),
              $urandom, $urandom, last};
        return p;
    endfunction

    task automatic cfg_write(logic idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // sender holds off until every word of queued tracks is back
    task automatic drain();
        while (pending_points.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // random track: bins on a line with optional noise; wild tracks use any bits
    task automatic add_track(int npts, int mode);
        longint t0, step, f0, slp, k;
        t_point p;
        int     nb;
        nb = $urandom_range(1, npts);
        t0 = qv($urandom_range(0, 4000)) - qv(2000) + $urandom;
        step = longint'($urandom_range(1, 1 << 20)) <<< $urandom_range(4, 20);
        f0 = longint'($urandom) <<< $urandom_range(0, 24);
        slp = longint'($urandom_range(0, 4000)) - 2000;
        for (int i = 0; i < npts; i++) begin
            k = $urandom_range(0, nb - 1);
            if (mode == 2) begin
                p = '{rnd64(), rnd64(), rnd64(), 63'(rnd64()), 63'(rnd64()),
                      63'(rnd64()), 63'(rnd64()), 16'($urandom), $urandom, $urandom,
                      1'b0};
                if ($urandom_range(1) == 1) p.tacq = t0;
            end else begin
                p = mkpt(t0 + k * step, t0 + k * step + $urandom_range(0, 1 << 16),
                         f0 + k * slp * step / 64 +
                             (mode == 1 ? longint'($urandom) <<< 4 : 0),
                         longint'($urandom_range(0, 1 << 24)) <<< 16,
                         longint'($urandom_range(1, 1 << 20)) <<< 16,
                         longint'($urandom_range(1, 1 << 24)) <<< 16,
                         longint'($urandom) <<< 8, 0);
            end
            p.last = (i == npts - 1);
            queue_point(p);
        end
    endtask

    initial begin
        int items;
        int n;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_time_in_acq = 0;
        i_time_in_run = 0;
        i_frequency = 0;
        i_amplitude = 0;
        i_noise_mean = 0;
        i_noise_variance = 0;
        i_wide_amplitude = 0;
        i_component = 0;
        i_acquisition_id = 0;
        i_candidate_id = 0;
        i_last_point = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_SLOPE_MIN;
        i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // single-point tracks at the field extremes, zero noise in the second
        queue_point('{QMIN, QMAX, QMIN, '1, 63'd1, 63'd1, '1, 16'hFFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1});
        queue_point('{QMAX, QMIN, QMAX, '0, '0, '0, '0, '0, '0, '0, 1});
        // two bins, one merged twice, one with zero power
        queue_point(mkpt(qv(5), qv(7), qv(100), qv(2), qv(1), qv(1), qv(3), 0));
        queue_point(mkpt(qv(6), qv(9), qv(50), 0, qv(1), qv(4), qv(1), 0));
        queue_point(mkpt(qv(5), qv(8), qv(120), qv(6), qv(2), qv(9), 0, 1));
        drain();
        cfg_write(CFG_ASSIGNED_ERR, 64'h0000_0000_8000_0000);
        cfg_write(CFG_SLOPE_MIN, 64'd0);
        // exact line: small chi-square takes the assigned error
        for (int i = 0; i < 5; i++)
            queue_point(mkpt(qv(i + 1), qv(i), qv(1000 + 3 * i), qv(4),
                             qv(1), qv(2), qv(5), i == 4));
        // scattered line
        for (int i = 0; i < 6; i++)
            queue_point(mkpt(qv(i - 2), qv(10 - i), qv(200 - 7 * i * i),
                             qv(i + 1), qv(2), qv(3), qv(1), i == 5));
        drain();
        cfg_write(CFG_SLOPE_MIN, QMAX);
        cfg_write(CFG_ASSIGNED_ERR, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_point(mkpt(qv(1), qv(1), qv(10), qv(1), qv(1), qv(1), qv(1), 0));
        queue_point(mkpt(qv(2), qv(2), qv(12), qv(1), qv(1), qv(1), qv(1), 0));
        queue_point(mkpt(qv(3), qv(3), qv(14), qv(1), qv(1), qv(1), qv(1), 1));
        drain();

        cfg_write(CFG_SLOPE_MIN, -64'sd4 <<< FRAC_BITS);
        cfg_write(CFG_ASSIGNED_ERR, 64'h0000_0001_2345_6789);
        items = 0;
        while (items < 91) begin
            // a long stretch with no idling on either side
            calm = (items >= 20 && items < 50);
            n = $urandom_range(1, 8);
            add_track(n, $urandom_range(99) < 15 ? 2 : $urandom_range(1));
            items += n;
            if (items > 40 && items <= 48) begin
                drain();
                cfg_write(CFG_SLOPE_MIN, rnd64());
                cfg_write(CFG_ASSIGNED_ERR, {1'b0, $urandom_range(0, 1 << 20), 31'd0});
            end
        end
        drain();
        calm = 0;
        repeat (1500) @(posedge i_clk);
        if (errs == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wtlf_pkg.sv
design/wtlf_alu.sv
design/weighted_track_line_fit.sv
tb/tb_top.sv
